// ----- src/chm_pkg.sv -----
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants of the chained hash map engine
// Payload structs, function and status codes, controller interface structs.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int BUCKETS     = 64;
    localparam int ENTRIES     = 256;
    localparam int CHAIN_LIMIT = 256;
    localparam int BW = $clog2(BUCKETS);
    localparam int EW = $clog2(ENTRIES);
    localparam int PW = EW + 1;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;
    localparam logic [1:0] FUNC_NOP    = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [PW-1:0] NIL = PW'(ENTRIES);

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]    status;
        logic          found;
        logic [31:0]   value_out;
        logic [PW-1:0] entry_total;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request, read bucket head
        logic step;     // take head, or read entry at cursor and advance
        logic finish;   // apply update, register result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic walk_end;  // cursor is nil, hit, or walk exhausted
    } t_sts;

endpackage

// ----- src/chm_datapath.sv -----
// ----------------------------------------------------------------------------
// chm_datapath: chain walk datapath
// Holds bucket heads, entry memories and the free stack; walks the chain one entry at a time.
// ----------------------------------------------------------------------------
module chm_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  chm_pkg::t_req i_req,
    input  chm_pkg::t_cmd i_cmd,
    output chm_pkg::t_sts o_sts,
    output chm_pkg::t_rsp o_rsp
);
    import chm_pkg::*;

    // bucket heads: valid bits, stored head
    logic [BUCKETS-1:0] r_head_vld;
    logic [PW-1:0]      r_head [BUCKETS];
    // entry memories
    logic [31:0]        m_key  [ENTRIES];
    logic [31:0]        m_val  [ENTRIES];
    logic [PW-1:0]      m_link [ENTRIES];
    logic [EW-1:0]      m_free [ENTRIES];
    logic [PW-1:0]      r_free_total, r_held_total;
    logic [PW-1:0]      r_init_mark;  // slots below this in pool are unwritten

    t_req          r_req;
    logic [BW-1:0] r_bkt;
    logic [PW-1:0] r_cur, r_prev, r_tail, r_hit, r_len, r_steps;
    logic          r_hitf;
    logic [31:0]   r_rd_key, r_rd_val;
    logic [PW-1:0] r_rd_link, r_hit_link;
    logic [31:0]   r_hit_val;
    logic          r_rd_vld;
    logic [PW-1:0] r_head_rd;
    logic          r_head_pend;
    logic [EW-1:0] r_pop;
    t_rsp          r_rsp;

    // walk step: r_cur addresses memory; data arrives next cycle
    logic w_cur_ok, w_match;
    assign w_cur_ok = (r_cur < NIL);
    assign w_match  = r_rd_vld && (r_rd_key == r_req.key);

    assign o_sts.walk_end = !r_head_pend &&
                            (r_hitf || (!r_rd_vld && (!w_cur_ok || r_steps == NIL)));
    assign o_rsp = r_rsp;

    logic [EW-1:0] w_cur_i;
    assign w_cur_i = r_cur[EW-1:0];

    logic [BW-1:0] w_req_bkt;
    assign w_req_bkt = i_req.key[BW-1:0];

    logic [PW-1:0] w_ft_m1;
    assign w_ft_m1 = r_free_total - PW'(1);

    always_ff @(posedge i_clk) begin
        r_rd_key  <= m_key[w_cur_i];
        r_rd_val  <= m_val[w_cur_i];
        r_rd_link <= m_link[w_cur_i];
        r_pop     <= m_free[w_ft_m1[EW-1:0]];
        r_head_rd <= r_head_vld[w_req_bkt] ? r_head[w_req_bkt] : NIL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld   <= '0;
            r_free_total <= NIL;
            r_held_total <= '0;
            r_init_mark  <= NIL;
            r_rd_vld     <= 1'b0;
            r_hitf       <= 1'b0;
            r_head_pend  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_req       <= i_req;
                r_bkt       <= w_req_bkt;
                r_head_pend <= 1'b1;
                r_prev      <= NIL;
                r_tail      <= NIL;
                r_len       <= '0;
                r_steps     <= '0;
                r_hitf      <= 1'b0;
                r_rd_vld    <= 1'b0;
            end else if (i_cmd.step) begin
                if (r_head_pend) begin
                    // head read registered at the accepting edge
                    r_head_pend <= 1'b0;
                    r_cur       <= r_head_rd;
                end else if (r_rd_vld) begin
                    // examine entry fetched last cycle
                    r_rd_vld <= 1'b0;
                    r_len    <= r_len + PW'(1);
                    r_tail   <= r_cur;
                    if (w_match) begin
                        r_hitf     <= 1'b1;
                        r_hit      <= r_cur;
                        r_hit_val  <= r_rd_val;
                        r_hit_link <= r_rd_link;
                    end else begin
                        r_prev <= r_cur;
                        r_cur  <= r_rd_link;
                    end
                end else if (w_cur_ok && r_steps != NIL && !r_hitf) begin
                    r_rd_vld <= 1'b1;
                    r_steps  <= r_steps + PW'(1);
                end
            end
            if (i_cmd.finish) begin
                t_rsp          n_rsp;
                logic [EW-1:0] slot;
                n_rsp.status      = ST_MISS;
                n_rsp.found       = 1'b0;
                n_rsp.value_out   = '0;
                n_rsp.entry_total = r_held_total;
                slot = (w_ft_m1 < r_init_mark) ? w_ft_m1[EW-1:0] : r_pop;
                unique case (r_req.func)
                    FUNC_INSERT: begin
                        if (r_hitf) begin
                            m_val[r_hit[EW-1:0]] <= r_req.value;
                            n_rsp.status = ST_DONE;
                            n_rsp.found  = 1'b1;
                        end else if (r_free_total == '0 || r_len >= PW'(CHAIN_LIMIT)) begin
                            n_rsp.status = ST_FULL;
                        end else begin
                            r_free_total <= w_ft_m1;
                            if (w_ft_m1 < r_init_mark) r_init_mark <= w_ft_m1;
                            m_key[slot]  <= r_req.key;
                            m_val[slot]  <= r_req.value;
                            m_link[slot] <= NIL;
                            if (r_tail == NIL) begin
                                r_head[r_bkt]     <= {1'b0, slot};
                                r_head_vld[r_bkt] <= 1'b1;
                            end else begin
                                m_link[r_tail[EW-1:0]] <= {1'b0, slot};
                            end
                            r_held_total      <= r_held_total + PW'(1);
                            n_rsp.entry_total = r_held_total + PW'(1);
                            n_rsp.status      = ST_DONE;
                        end
                    end
                    FUNC_LOOKUP: begin
                        if (r_hitf) begin
                            n_rsp.status    = ST_DONE;
                            n_rsp.found     = 1'b1;
                            n_rsp.value_out = r_hit_val;
                        end
                    end
                    FUNC_DELETE: begin
                        if (r_hitf) begin
                            if (r_prev == NIL) begin
                                r_head[r_bkt]     <= r_hit_link;
                                r_head_vld[r_bkt] <= 1'b1;
                            end else begin
                                m_link[r_prev[EW-1:0]] <= r_hit_link;
                            end
                            if (r_free_total < NIL) begin
                                m_free[r_free_total[EW-1:0]] <= r_hit[EW-1:0];
                                r_free_total <= r_free_total + PW'(1);
                                if (r_free_total < r_init_mark)
                                    r_init_mark <= r_free_total;
                            end
                            if (r_held_total != '0) begin
                                r_held_total      <= r_held_total - PW'(1);
                                n_rsp.entry_total = r_held_total - PW'(1);
                            end
                            n_rsp.status = ST_DONE;
                            n_rsp.found  = 1'b1;
                        end
                    end
                    default: ;
                endcase
                r_rsp <= n_rsp;
            end
        end
    end
endmodule

// ----- src/chm_ctrl.sv -----
// ----------------------------------------------------------------------------
// chm_ctrl: request sequencer
// Accepts a request, steps the chain walk, finishes and holds the result item.
// ----------------------------------------------------------------------------
module chm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  chm_pkg::t_sts i_sts,
    output chm_pkg::t_cmd o_cmd
);
    import chm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_FIN  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                o_cmd.load = 1'b1;
                n_state    = S_WALK;
            end
            S_WALK: begin
                if (i_sts.walk_end) n_state = S_FIN;
                else o_cmd.step = 1'b1;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
endmodule

// ----- src/chained_hash_map_engine_core.sv -----
// ----------------------------------------------------------------------------
// chained_hash_map_engine_core: separate chaining key/value table
// One request in flight: load, head read, chain walk, update, result hold.
// ----------------------------------------------------------------------------
// o_valid rises after a request is accepted, once the walk over the chain
// entries visited (at most 256) ends: the walk first takes the registered
// bucket head, each visited entry costs one registered read of the entry
// memories and one compare, then S_WALK ends the walk and S_FIN applies the
// update. The next request is accepted no sooner than the cycle after the
// result is taken, so only one request is handled at a time. Bucket is
// key mod 64.
module chained_hash_map_engine_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  chm_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output chm_pkg::t_rsp o_rsp
);
    import chm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    chm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    chm_datapath u_dp (
        .i_clk, .i_rst_n, .i_req, .i_cmd(w_cmd), .o_sts(w_sts), .o_rsp
    );

`ifndef ASSERT_OFF
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.step, w_cmd.finish}))
        else $error("overlapping commands");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("accept while result held");
    a_fin_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> o_valid)
        else $error("result not presented");
`endif
endmodule
